FILE: rtl/dq_pkg.sv
// ----------------------------------------------------------------------------
// dq_pkg
// Shared constants and types for the double-ended queue ring: operation and
// status codes, default sizes and the per-cell command set.
// ----------------------------------------------------------------------------
package dq_pkg;

    // Default sizes
    localparam int DEPTH_DEF      = 16;
    localparam int VALUE_BITS_DEF = 64;

    // Fixed port widths
    localparam int OP_W     = 3;
    localparam int VALUE_W  = 64;
    localparam int STATUS_W = 2;

    // Operation codes
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [OP_W-1:0] OP_REVERSE    = 3'd4;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_DONE       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL       = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY      = 2'd2;

    // Command broadcast to every cell of the chain
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_SHIFT_IN,   // take the left neighbor, new entry enters cell 0
        CELL_APPEND,     // first free cell takes the pushed value
        CELL_SHIFT_OUT,  // take the right neighbor, cell 0 drops out
        CELL_DROP_TAIL   // last occupied cell frees itself
    } cell_cmd_t;

endpackage

FILE: rtl/dq_cell.sv
// ----------------------------------------------------------------------------
// dq_cell
// One slot of the queue chain. Holds a value and an occupied bit, and moves
// them to or from its neighbors on the broadcast command.
// ----------------------------------------------------------------------------
module dq_cell #(
    parameter int VALUE_BITS = dq_pkg::VALUE_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  dq_pkg::cell_cmd_t     cmd,
    input  logic [VALUE_BITS-1:0] push_value,
    input  logic [VALUE_BITS-1:0] left_value,
    input  logic                  left_occ,
    input  logic [VALUE_BITS-1:0] right_value,
    input  logic                  right_occ,
    output logic [VALUE_BITS-1:0] value,
    output logic                  occ,
    output logic [VALUE_BITS-1:0] tail_value
);

    logic [VALUE_BITS-1:0] value_reg;
    logic [VALUE_BITS-1:0] value_next;
    logic                  occ_reg;
    logic                  occ_next;

    // Pick the next contents from the command and the neighbors
    always_comb
    begin
        value_next = value_reg;
        occ_next   = occ_reg;
        unique case (cmd)
            dq_pkg::CELL_SHIFT_IN:
            begin
                value_next = left_value;
                occ_next   = left_occ;
            end
            dq_pkg::CELL_APPEND:
            begin
                if (!occ_reg && left_occ)
                begin
                    value_next = push_value;
                    occ_next   = 1'b1;
                end
            end
            dq_pkg::CELL_SHIFT_OUT:
            begin
                value_next = right_value;
                occ_next   = right_occ;
            end
            dq_pkg::CELL_DROP_TAIL:
            begin
                if (occ_reg && !right_occ)
                    occ_next = 1'b0;
            end
            default:
            begin
                value_next = value_reg;
                occ_next   = occ_reg;
            end
        endcase
    end

    // Occupied bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            occ_reg <= 1'b0;
        else
            occ_reg <= occ_next;
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value      = value_reg;
    assign occ        = occ_reg;
    // Show the value only from the last occupied cell
    assign tail_value = (occ_reg && !right_occ) ? value_reg : '0;

endmodule

FILE: rtl/double_ended_queue_ring.sv
// ----------------------------------------------------------------------------
// double_ended_queue_ring
// Bounded double-ended queue built as a chain of cells with a reverse flag.
// ----------------------------------------------------------------------------
// Each input beat is one operation (push front or back, pop front or back,
// reverse) and yields one result beat with the front and back values, the
// entry count, an empty flag and a status. Entries sit packed in a chain of
// DEPTH cells starting at cell 0; pushing or popping at the chain head shifts
// every cell by one place. Reverse only flips which chain end counts as the
// front. One operation is in flight at a time: the cells update at the
// accepting edge, and the result register samples the settled cells once the
// output register is free. The input stalls while a beat is pending in the
// cells, so the block takes no new beat until the result register has loaded
// the previous one. Reset clears all occupied bits at once; no clearing pass
// is needed.
// ----------------------------------------------------------------------------
module double_ended_queue_ring #(
    parameter int DEPTH      = dq_pkg::DEPTH_DEF,
    parameter int VALUE_BITS = dq_pkg::VALUE_BITS_DEF,
    localparam int CNT_W     = $clog2(DEPTH + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [dq_pkg::OP_W-1:0]       op,
    input  logic [dq_pkg::VALUE_W-1:0]    item_value,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [dq_pkg::VALUE_W-1:0]    front_value,
    output logic [dq_pkg::VALUE_W-1:0]    back_value,
    output logic [CNT_W-1:0]              entry_count,
    output logic                          is_empty,
    output logic [dq_pkg::STATUS_W-1:0]   status
);

    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic                            in_accept;
    logic                            full;
    logic                            empty;
    logic                            at_first;
    dq_pkg::cell_cmd_t               cmd;
    logic [VALUE_BITS-1:0]           push_value;

    logic [CNT_W-1:0]                count_reg;
    logic [CNT_W-1:0]                count_next;
    logic                            rev_reg;
    logic                            rev_next;
    logic                            pending_reg;
    logic [dq_pkg::STATUS_W-1:0]     st_reg;
    logic [dq_pkg::STATUS_W-1:0]     st_next;

    logic                            out_valid_reg;
    logic [dq_pkg::VALUE_W-1:0]      front_reg;
    logic [dq_pkg::VALUE_W-1:0]      back_reg;
    logic [CNT_W-1:0]                cnt_out_reg;
    logic                            empty_out_reg;
    logic [dq_pkg::STATUS_W-1:0]     st_out_reg;
    logic                            load_result;

    logic [DEPTH-1:0][VALUE_BITS-1:0] value_vec;
    logic [DEPTH-1:0][VALUE_BITS-1:0] tail_vec;
    logic [DEPTH-1:0]                 occ_vec;
    logic [VALUE_BITS-1:0][DEPTH-1:0] tail_col;
    logic [VALUE_BITS-1:0]            first_phys;
    logic [VALUE_BITS-1:0]            last_phys;

    assign in_stall   = pending_reg;
    assign in_accept  = in_valid && !pending_reg;
    assign full       = (count_reg == FULL_CNT);
    assign empty      = (count_reg == '0);
    assign push_value = item_value[VALUE_BITS-1:0];

    // Decode the operation into a chain command and next control state
    always_comb
    begin
        cmd        = dq_pkg::CELL_HOLD;
        count_next = count_reg;
        rev_next   = rev_reg;
        st_next    = dq_pkg::ST_DONE;
        at_first   = 1'b0;
        if (in_accept)
        begin
            unique case (op) inside
                dq_pkg::OP_PUSH_FRONT, dq_pkg::OP_PUSH_BACK:
                begin
                    at_first = (op == dq_pkg::OP_PUSH_FRONT) != rev_reg;
                    if (full)
                        st_next = dq_pkg::ST_FULL;
                    else
                    begin
                        cmd        = at_first ? dq_pkg::CELL_SHIFT_IN : dq_pkg::CELL_APPEND;
                        count_next = count_reg + 1'b1;
                    end
                end
                dq_pkg::OP_POP_FRONT, dq_pkg::OP_POP_BACK:
                begin
                    at_first = (op == dq_pkg::OP_POP_FRONT) != rev_reg;
                    if (empty)
                        st_next = dq_pkg::ST_EMPTY;
                    else
                    begin
                        cmd        = at_first ? dq_pkg::CELL_SHIFT_OUT : dq_pkg::CELL_DROP_TAIL;
                        count_next = count_reg - 1'b1;
                    end
                end
                dq_pkg::OP_REVERSE:
                begin
                    rev_next = !rev_reg;
                end
                default:
                begin
                    st_next = dq_pkg::ST_DONE;
                end
            endcase
        end
    end

    // Chain of cells
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [VALUE_BITS-1:0] lv;
        logic                  lo;
        logic [VALUE_BITS-1:0] rv;
        logic                  ro;

        if (i == 0)
        begin : g_head
            assign lv = push_value;
            assign lo = 1'b1;
        end
        else
        begin : g_mid_l
            assign lv = value_vec[i-1];
            assign lo = occ_vec[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign rv = '0;
            assign ro = 1'b0;
        end
        else
        begin : g_mid_r
            assign rv = value_vec[i+1];
            assign ro = occ_vec[i+1];
        end

        dq_cell #(
            .VALUE_BITS (VALUE_BITS)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .cmd         (cmd),
            .push_value  (push_value),
            .left_value  (lv),
            .left_occ    (lo),
            .right_value (rv),
            .right_occ   (ro),
            .value       (value_vec[i]),
            .occ         (occ_vec[i]),
            .tail_value  (tail_vec[i])
        );
    end

    // Gather the tail value: one bit column per value bit, then reduce
    always_comb
    begin
        for (int b = 0; b < VALUE_BITS; b++)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                tail_col[b][i] = tail_vec[i][b];
            end
        end
    end

    for (genvar b = 0; b < VALUE_BITS; b++)
    begin : g_tail_or
        assign last_phys[b] = |tail_col[b];
    end

    assign first_phys  = occ_vec[0] ? value_vec[0] : '0;
    assign load_result = pending_reg && (!out_valid_reg || !out_stall);

    // Control state and output handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rev_reg       <= 1'b0;
            pending_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            rev_reg   <= rev_next;
            if (in_accept)
                pending_reg <= 1'b1;
            else if (load_result)
                pending_reg <= 1'b0;
            if (load_result)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Hold the status of the beat in flight
    always_ff @(posedge clk)
    begin
        if (in_accept)
            st_reg <= st_next;
    end

    // Result register, loaded from the settled cells
    always_ff @(posedge clk)
    begin
        if (load_result)
        begin
            front_reg     <= dq_pkg::VALUE_W'(rev_reg ? last_phys : first_phys);
            back_reg      <= dq_pkg::VALUE_W'(rev_reg ? first_phys : last_phys);
            cnt_out_reg   <= count_reg;
            empty_out_reg <= empty;
            st_out_reg    <= st_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign front_value = front_reg;
    assign back_value  = back_reg;
    assign entry_count = cnt_out_reg;
    assign is_empty    = empty_out_reg;
    assign status      = st_out_reg;

    // Count never exceeds the chain length
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("entry count beyond depth");

    // Occupied cells agree with the count
    a_occ_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(occ_vec) == int'(count_reg))
        else $error("occupied cells disagree with count");

    // Occupied cells form one run starting at cell 0
    a_occ_packed: assert property (@(posedge clk) disable iff (!rst_n)
        (occ_vec & (occ_vec + 1'b1)) == '0)
        else $error("occupied cells not packed at chain head");

    // A refused push leaves the count alone
    a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && full && (op == dq_pkg::OP_PUSH_FRONT || op == dq_pkg::OP_PUSH_BACK))
        |=> $stable(count_reg))
        else $error("refused push changed count");

    // An accepted beat always produces a pending result
    a_accept_pending: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> pending_reg)
        else $error("accepted beat not pending");

endmodule
